// File: hdl/dip_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dip_pkg
// Shared types, constants and part-handling functions of the dotted IPv4
// address parser.
// ----------------------------------------------------------------------------
package dip_pkg;

  localparam int CH_W = 8;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 40;

  localparam logic [7:0] DOT_CHAR = 8'h2e;
  localparam logic [7:0] PLUS_CHAR = 8'h2b;
  localparam logic [7:0] MINUS_CHAR = 8'h2d;
  localparam logic [7:0] NUL_CHAR = 8'h00;
  localparam logic [7:0] ZERO_CHAR = 8'h30;
  localparam logic [8:0] PART_LIMIT = 9'd256;
  localparam logic [2:0] PART_MAX = 3'd4;

  typedef enum logic [5:0] {
    PH_START  = 6'b000001,
    PH_SPACE  = 6'b000010,
    PH_SIGN   = 6'b000100,
    PH_ZERO   = 6'b001000,
    PH_HEXPRE = 6'b010000,
    PH_DIGITS = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_t;

  typedef struct packed {
    phase_t          phase;
    logic [2:0]      part_index;
    logic [8:0]      part_value;
    logic            value_overflow;
    logic            minus_seen;
    radix_t          radix_mode;
    logic [3:0][7:0] address_bytes;
    logic            rejected;
    logic            stopped;
  } dip_state_t;

  typedef struct packed {
    logic [2:0]  part_count;
    logic [31:0] address;
    logic        valid_res;
  } dip_result_t;

  function automatic dip_state_t reset_state();
    dip_state_t r;
    r.phase          = PH_START;
    r.part_index     = 3'd0;
    r.part_value     = 9'd0;
    r.value_overflow = 1'b0;
    r.minus_seen     = 1'b0;
    r.radix_mode     = RADIX_DEC;
    r.address_bytes  = '0;
    r.rejected       = 1'b0;
    r.stopped        = 1'b0;
    return r;
  endfunction

  // {ok, digit}
  function automatic logic [4:0] digit_of(logic [7:0] c, radix_t rad);
    logic [7:0] v;
    logic       ok;
    ok = 1'b1;
    v  = 8'd0;
    if (c >= 8'd48 && c <= 8'd57) v = c - 8'd48;
    else if (c >= 8'd97 && c <= 8'd102) v = c - 8'd87;
    else if (c >= 8'd65 && c <= 8'd70) v = c - 8'd55;
    else ok = 1'b0;
    if (rad == RADIX_OCT && v > 8'd7) ok = 1'b0;
    if (rad == RADIX_DEC && v > 8'd9) ok = 1'b0;
    return {ok, v[3:0]};
  endfunction

  function automatic dip_state_t accumulate(dip_state_t s, logic [3:0] d);
    logic [12:0] t;
    dip_state_t  r;
    r = s;
    case (s.radix_mode)
      RADIX_HEX: t = {s.part_value, 4'b0000} + 13'(d);
      RADIX_OCT: t = {1'b0, s.part_value, 3'b000} + 13'(d);
      default:   t = {1'b0, s.part_value, 3'b000} + {3'b000, s.part_value, 1'b0} + 13'(d);
    endcase
    if (t >= 13'(PART_LIMIT)) begin
      r.value_overflow = 1'b1;
      r.part_value     = PART_LIMIT;
    end else begin
      r.part_value = t[8:0];
    end
    return r;
  endfunction

  function automatic dip_state_t end_part(dip_state_t s);
    dip_state_t r;
    r = s;
    if (s.value_overflow || (s.minus_seen && s.part_value != 9'd0)) begin
      r.rejected = 1'b1;
    end else begin
      r.address_bytes[s.part_index[1:0]] = s.part_value[7:0];
      r.part_index     = s.part_index + 3'd1;
      r.part_value     = 9'd0;
      r.value_overflow = 1'b0;
      r.minus_seen     = 1'b0;
      r.radix_mode     = RADIX_DEC;
      r.phase          = PH_START;
      if (r.part_index >= PART_MAX) r.stopped = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/dip_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dip_step
// Next parser state for one non-NUL character.
// ----------------------------------------------------------------------------
module dip_step (
  input  wire dip_pkg::dip_state_t st,
  input  wire logic [7:0]          ch,
  output dip_pkg::dip_state_t      st_next
);

  logic is_space;
  logic is_sign;
  logic is_x;
  logic [4:0] dig_oct;
  logic [4:0] dig_hex;
  logic [4:0] dig_cur;

  assign is_space = (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
  assign is_sign  = (ch == dip_pkg::PLUS_CHAR) || (ch == dip_pkg::MINUS_CHAR);
  assign is_x     = (ch == 8'd120) || (ch == 8'd88);
  assign dig_oct  = dip_pkg::digit_of(ch, dip_pkg::RADIX_OCT);
  assign dig_hex  = dip_pkg::digit_of(ch, dip_pkg::RADIX_HEX);
  assign dig_cur  = dip_pkg::digit_of(ch, st.radix_mode);

  always_comb begin
    dip_pkg::dip_state_t s;
    logic lead;
    s = st;
    lead = 1'b0;
    if (!st.rejected && !st.stopped) begin
      unique case (st.phase)
        dip_pkg::PH_START: begin
          if (ch == dip_pkg::DOT_CHAR) s = dip_pkg::end_part(st);
          else lead = 1'b1;
        end
        dip_pkg::PH_SPACE: lead = 1'b1;
        dip_pkg::PH_SIGN: begin
          if (ch == dip_pkg::ZERO_CHAR) begin
            s.phase = dip_pkg::PH_ZERO;
          end else if (ch >= 8'd49 && ch <= 8'd57) begin
            s.radix_mode = dip_pkg::RADIX_DEC;
            s.part_value = {1'b0, ch - dip_pkg::ZERO_CHAR};
            s.phase      = dip_pkg::PH_DIGITS;
          end else begin
            s.rejected = 1'b1;
          end
        end
        dip_pkg::PH_ZERO: begin
          if (is_x) begin
            s.phase = dip_pkg::PH_HEXPRE;
          end else if (ch == dip_pkg::DOT_CHAR) begin
            s = dip_pkg::end_part(st);
          end else if (!dig_oct[4]) begin
            s.rejected = 1'b1;
          end else begin
            s.radix_mode = dip_pkg::RADIX_OCT;
            s = dip_pkg::accumulate(s, dig_oct[3:0]);
            s.phase = dip_pkg::PH_DIGITS;
          end
        end
        dip_pkg::PH_HEXPRE: begin
          if (!dig_hex[4]) begin
            s.rejected = 1'b1;
          end else begin
            s.radix_mode = dip_pkg::RADIX_HEX;
            s = dip_pkg::accumulate(s, dig_hex[3:0]);
            s.phase = dip_pkg::PH_DIGITS;
          end
        end
        dip_pkg::PH_DIGITS: begin
          if (ch == dip_pkg::DOT_CHAR) s = dip_pkg::end_part(st);
          else if (!dig_cur[4]) s.rejected = 1'b1;
          else s = dip_pkg::accumulate(st, dig_cur[3:0]);
        end
        default: s.rejected = 1'b1;
      endcase
      // whitespace, sign or first digit of a part
      if (lead) begin
        if (is_space) begin
          s.phase = dip_pkg::PH_SPACE;
        end else if (is_sign) begin
          s.minus_seen = (ch == dip_pkg::MINUS_CHAR);
          s.phase      = dip_pkg::PH_SIGN;
        end else if (ch == dip_pkg::ZERO_CHAR) begin
          s.phase = dip_pkg::PH_ZERO;
        end else if (ch >= 8'd49 && ch <= 8'd57) begin
          s.radix_mode = dip_pkg::RADIX_DEC;
          s.part_value = {1'b0, ch - dip_pkg::ZERO_CHAR};
          s.phase      = dip_pkg::PH_DIGITS;
        end else begin
          s.rejected = 1'b1;
        end
      end
    end
    st_next = s;
  end

endmodule
`default_nettype wire

// File: hdl/dip_finish.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dip_finish
// Closes the last part at end of string and expands classful short forms.
// ----------------------------------------------------------------------------
module dip_finish (
  input  wire dip_pkg::dip_state_t st,
  output dip_pkg::dip_result_t     res
);

  always_comb begin
    dip_pkg::dip_state_t s;
    logic [7:0] b0, b1, b2, b3;
    logic [1:0] cls;
    logic       ok;
    s = st;
    if (!st.rejected && !st.stopped) begin
      if (st.phase == dip_pkg::PH_SPACE || st.phase == dip_pkg::PH_SIGN ||
          st.phase == dip_pkg::PH_HEXPRE) begin
        s.rejected = 1'b1;
      end else if (st.phase == dip_pkg::PH_ZERO || st.phase == dip_pkg::PH_DIGITS) begin
        s = dip_pkg::end_part(st);
      end
    end
    ok  = !s.rejected;
    b0  = s.address_bytes[0];
    b1  = s.address_bytes[1];
    b2  = s.address_bytes[2];
    b3  = s.address_bytes[3];
    cls = b0[7:6];
    if (ok) begin
      if (s.part_index == 3'd4) begin
        ok = 1'b1;
      end else if (s.part_index == 3'd3 && cls <= 2'd1) begin
        b3 = b2;
        b2 = b1;
        b1 = 8'd0;
      end else if (s.part_index == 3'd2 && cls <= 2'd1) begin
        b3 = b1;
        b2 = 8'd0;
        b1 = 8'd0;
      end else if (s.part_index == 3'd3 && cls == 2'd2) begin
        b3 = b2;
        b2 = 8'd0;
      end else begin
        ok = 1'b0;
      end
    end
    res.valid_res  = ok;
    res.address    = ok ? {b0, b1, b2, b3} : 32'd0;
    res.part_count = s.part_index;
  end

endmodule
`default_nettype wire

// File: hdl/dotted_ipv4_address_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dotted_ipv4_address_parser
// Parses a dotted IPv4 address string, one character per request.
// ----------------------------------------------------------------------------
// Input stream s_axis carries one character per request in tdata[7:0];
// a NUL character ends the string. Each NUL gives exactly one request on
// m_axis: tdata[0] valid flag, tdata[32:1] address (first part in the
// high byte), tdata[35:33] part count, upper bits zero.
// A character is registered on acceptance and folded into the parser
// state in the following cycle, one character per cycle, unless it is a
// NUL held for a pending result. A NUL's result is taken from the parser
// state into the output register as the NUL leaves the input register.
// Synchronous reset clears the parser state and drops any pending
// result. While the receiver stalls, characters keep flowing until a NUL
// waits in the input register with s_axis_tready low until the pending result is taken.
// ----------------------------------------------------------------------------
module dotted_ipv4_address_parser (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [dip_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // ch
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [dip_pkg::OUT_DATA_W-1:0]        m_axis_tdata   // valid_res, address, part_count
);

  logic [7:0]           ch_q;
  logic                 ch_vld;
  dip_pkg::dip_state_t  st;
  dip_pkg::dip_state_t  st_next;
  dip_pkg::dip_result_t fin;
  dip_pkg::dip_result_t out_q;
  logic                 out_vld;
  logic                 is_nul;
  logic                 advance;
  logic                 load_out;

  dip_step u_step (
    .st      (st),
    .ch      (ch_q),
    .st_next (st_next)
  );

  dip_finish u_finish (
    .st  (st),
    .res (fin)
  );

  assign is_nul        = (ch_q == dip_pkg::NUL_CHAR);
  assign advance       = ch_vld && (!is_nul || !out_vld || m_axis_tready);
  assign load_out      = advance && is_nul;
  assign s_axis_tready = !ch_vld || advance;

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) ch_q <= s_axis_tdata[dip_pkg::CH_W-1:0];
    if (load_out) out_q <= fin;
    if (rst) begin
      ch_vld  <= 1'b0;
      out_vld <= 1'b0;
      st      <= dip_pkg::reset_state();
    end else begin
      if (s_axis_tready) ch_vld <= s_axis_tvalid;
      if (load_out) out_vld <= 1'b1;
      else if (m_axis_tready) out_vld <= 1'b0;
      if (advance) begin
        if (is_nul) st <= dip_pkg::reset_state();
        else st <= st_next;
      end
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {4'b0000, out_q.part_count, out_q.address, out_q.valid_res};

endmodule
`default_nettype wire
